>>> hdl/cfcp_pkg.sv
// Shared definitions for the class file constant pool parser.
// Holds parse phase codes, tag codes, result kinds and the result record.
// No dependencies.
package cfcp_pkg;

    // Parse phase codes
    localparam logic [3:0] PH_MAGIC   = 4'd0;
    localparam logic [3:0] PH_VERSION = 4'd1;
    localparam logic [3:0] PH_COUNT   = 4'd2;
    localparam logic [3:0] PH_TAG     = 4'd3;
    localparam logic [3:0] PH_BODY    = 4'd4;
    localparam logic [3:0] PH_TEXT    = 4'd5;
    localparam logic [3:0] PH_FINISH  = 4'd6;
    localparam logic [3:0] PH_DONE    = 4'd7;
    localparam logic [3:0] PH_ERROR   = 4'd8;

    // Constant pool tag codes
    localparam logic [7:0] TAG_UTF8       = 8'd1;
    localparam logic [7:0] TAG_INTEGER    = 8'd3;
    localparam logic [7:0] TAG_FLOAT      = 8'd4;
    localparam logic [7:0] TAG_LONG       = 8'd5;
    localparam logic [7:0] TAG_DOUBLE     = 8'd6;
    localparam logic [7:0] TAG_CLASS      = 8'd7;
    localparam logic [7:0] TAG_STRING     = 8'd8;
    localparam logic [7:0] TAG_FIELDREF   = 8'd9;
    localparam logic [7:0] TAG_METHODREF  = 8'd10;
    localparam logic [7:0] TAG_IMETHODREF = 8'd11;
    localparam logic [7:0] TAG_NAMETYPE   = 8'd12;

    // Result kinds
    localparam logic [2:0] KIND_ENTRY     = 3'd0;
    localparam logic [2:0] KIND_TEXT      = 3'd1;
    localparam logic [2:0] KIND_FINISHED  = 3'd2;
    localparam logic [2:0] KIND_BAD_MAGIC = 3'd3;
    localparam logic [2:0] KIND_BAD_TAG   = 3'd4;

    localparam logic [31:0] CLASS_MAGIC = 32'hCAFEBABE;

    localparam int unsigned DATA_W = 112;

    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [15:0] index;
        logic [7:0]  tag;
        logic [63:0] value;
        logic [15:0] second;
        logic [7:0]  text_byte;
        logic        text_last;
    } t_result;

    // Body length in bytes for a tag, zero for an unknown tag
    function automatic logic [3:0] body_length(input logic [7:0] tag);
        logic [3:0] len;
        case (tag) inside
            TAG_UTF8, TAG_CLASS, TAG_STRING:          len = 4'd2;
            TAG_INTEGER, TAG_FLOAT:                   len = 4'd4;
            TAG_LONG, TAG_DOUBLE:                     len = 4'd8;
            TAG_FIELDREF, TAG_METHODREF,
            TAG_IMETHODREF, TAG_NAMETYPE:             len = 4'd4;
            default:                                  len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

>>> hdl/cfcp_parse.sv
// Parse state and per-byte next-state logic of the constant pool parser.
// Produces at most one result per accepted byte, combinationally.
// Depends on cfcp_pkg.
module cfcp_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_start,
    output cfcp_pkg::t_result o_result
);
    import cfcp_pkg::*;

    logic [3:0]  r_phase,  n_phase;
    logic [3:0]  r_left,   n_left;
    logic [63:0] r_shift,  n_shift;
    logic [15:0] r_count,  n_count;
    logic [15:0] r_entry,  n_entry;
    logic [7:0]  r_tag,    n_tag;
    logic [15:0] r_text,   n_text;

    logic [3:0]  e_phase;
    logic [3:0]  e_left;
    logic [63:0] e_shift;
    logic [15:0] e_count;
    logic [15:0] e_entry;
    logic [7:0]  e_tag;
    logic [15:0] e_text;

    logic [63:0] g_shift;
    logic [3:0]  g_left;
    logic        g_done;
    logic [16:0] adv1, adv2;
    logic [3:0]  adv1_phase, adv2_phase;
    logic [15:0] text_dec;
    logic [3:0]  tag_len;
    t_result     res;

    // Restart the parse on a start byte
    assign e_phase = i_start ? PH_MAGIC : r_phase;
    assign e_left  = i_start ? 4'd4     : r_left;
    assign e_shift = i_start ? 64'd0    : r_shift;
    assign e_count = i_start ? 16'd0    : r_count;
    assign e_entry = i_start ? 16'd1    : r_entry;
    assign e_tag   = i_start ? 8'd0     : r_tag;
    assign e_text  = i_start ? 16'd0    : r_text;

    // Shift the byte into the field gatherer
    assign g_shift = {e_shift[55:0], i_byte};
    assign g_left  = (e_left != 4'd0) ? e_left - 4'd1 : 4'd0;
    assign g_done  = (g_left == 4'd0);

    // Slot advance, computed wide so the top slot cannot wrap
    assign adv1       = {1'b0, e_entry} + 17'd1;
    assign adv2       = {1'b0, e_entry} + 17'd2;
    assign adv1_phase = (adv1 < {1'b0, e_count}) ? PH_TAG : PH_FINISH;
    assign adv2_phase = (adv2 < {1'b0, e_count}) ? PH_TAG : PH_FINISH;

    assign text_dec = (e_text != 16'd0) ? e_text - 16'd1 : 16'd0;
    assign tag_len  = body_length(i_byte);

    // Next state and result
    always_comb begin
        n_phase = e_phase;
        n_left  = e_left;
        n_shift = e_shift;
        n_count = e_count;
        n_entry = e_entry;
        n_tag   = e_tag;
        n_text  = e_text;
        res     = '0;
        unique case (e_phase)
            PH_MAGIC: begin
                n_shift = g_shift;
                n_left  = g_left;
                if (g_done) begin
                    if (g_shift[31:0] != CLASS_MAGIC) begin
                        n_phase   = PH_ERROR;
                        res.valid = 1'b1;
                        res.kind  = KIND_BAD_MAGIC;
                        res.value = {32'd0, g_shift[31:0]};
                    end else begin
                        n_phase = PH_VERSION;
                        n_left  = 4'd4;
                        n_shift = 64'd0;
                    end
                end
            end
            PH_VERSION: begin
                n_shift = g_shift;
                n_left  = g_left;
                if (g_done) begin
                    n_phase = PH_COUNT;
                    n_left  = 4'd2;
                    n_shift = 64'd0;
                end
            end
            PH_COUNT: begin
                n_shift = g_shift;
                n_left  = g_left;
                if (g_done) begin
                    n_count = g_shift[15:0];
                    n_entry = 16'd1;
                    n_shift = 64'd0;
                    n_phase = (g_shift[15:0] > 16'd1) ? PH_TAG : PH_FINISH;
                end
            end
            PH_TAG: begin
                n_tag = i_byte;
                if (tag_len == 4'd0) begin
                    n_phase   = PH_ERROR;
                    res.valid = 1'b1;
                    res.kind  = KIND_BAD_TAG;
                    res.index = e_entry;
                    res.tag   = i_byte;
                end else begin
                    n_left  = tag_len;
                    n_shift = 64'd0;
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                n_shift = g_shift;
                n_left  = g_left;
                if (g_done) begin
                    res.valid = 1'b1;
                    res.kind  = KIND_ENTRY;
                    res.index = e_entry;
                    res.tag   = e_tag;
                    case (e_tag) inside
                        TAG_UTF8: begin
                            n_text    = g_shift[15:0];
                            res.value = {48'd0, g_shift[15:0]};
                            if (g_shift[15:0] != 16'd0) begin
                                n_phase = PH_TEXT;
                            end else begin
                                n_entry = adv1[15:0];
                                n_phase = adv1_phase;
                            end
                        end
                        TAG_INTEGER, TAG_FLOAT: begin
                            res.value = {32'd0, g_shift[31:0]};
                            n_entry   = adv1[15:0];
                            n_phase   = adv1_phase;
                        end
                        TAG_LONG, TAG_DOUBLE: begin
                            res.value = g_shift;
                            n_entry   = adv2[15:0];
                            n_phase   = adv2_phase;
                        end
                        TAG_CLASS, TAG_STRING: begin
                            res.value = {48'd0, g_shift[15:0]};
                            n_entry   = adv1[15:0];
                            n_phase   = adv1_phase;
                        end
                        default: begin
                            res.value  = {48'd0, g_shift[31:16]};
                            res.second = g_shift[15:0];
                            n_entry    = adv1[15:0];
                            n_phase    = adv1_phase;
                        end
                    endcase
                end
            end
            PH_TEXT: begin
                n_text        = text_dec;
                res.valid     = 1'b1;
                res.kind      = KIND_TEXT;
                res.index     = e_entry;
                res.tag       = TAG_UTF8;
                res.text_byte = i_byte;
                res.text_last = (text_dec == 16'd0);
                if (text_dec == 16'd0) begin
                    n_entry = adv1[15:0];
                    n_phase = adv1_phase;
                end
            end
            PH_FINISH: begin
                n_phase   = PH_DONE;
                res.valid = 1'b1;
                res.kind  = KIND_FINISHED;
                res.index = e_count;
            end
            default: begin
                // Done or error: drop the byte
            end
        endcase
    end

    assign o_result = res;

    // Hold state between accepted bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_left  <= 4'd4;
            r_shift <= 64'd0;
            r_count <= 16'd0;
            r_entry <= 16'd1;
            r_tag   <= 8'd0;
            r_text  <= 16'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_shift <= n_shift;
            r_count <= n_count;
            r_entry <= n_entry;
            r_tag   <= n_tag;
            r_text  <= n_text;
        end
    end

endmodule

>>> hdl/class_file_constant_pool_parser.sv
// Top level of the class file constant pool parser: stream ports and result register.
// Instantiates cfcp_parse; depends on cfcp_pkg.
//
//  channel | direction | tdata                          | tuser        | tlast
//  s       | in        | [7:0] byte_in                  | [0] file_start | -
//  m       | out       | entry_index, entry_tag, entry_ | [2:0] result_kind | text_last
//          |           | value, second_ref, text_byte   |              |
//
// One byte is taken per cycle unless m stalls; a result appears in the result
// register in the cycle after its byte. The byte is parsed in the cycle it is
// accepted, so the only limit is the single result register: a byte is taken
// whenever that register is empty or being drained. Reset restarts the parse
// as if a file had just begun. A stall on m holds the result and back-pressures s.
module class_file_constant_pool_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] byte_in
    input  logic [0:0]   i_s_tuser,   // [0] file_start
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [cfcp_pkg::DATA_W-1:0] o_m_tdata,
    // [15:0] entry_index, [23:16] entry_tag, [87:24] entry_value,
    // [103:88] second_ref, [111:104] text_byte
    output logic [2:0]   o_m_tuser,   // [2:0] result_kind
    output logic         o_m_tlast    // text_last
);
    import cfcp_pkg::*;

    logic    accept;
    t_result result;
    logic    r_valid;
    t_result r_res;

    assign o_s_tready = !r_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    cfcp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .i_start  (i_s_tuser[0]),
        .o_result (result)
    );

    // Load the result register, drain it on a taken request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= accept && result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && result.valid) begin
            r_res <= result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_res.text_byte, r_res.second, r_res.value, r_res.tag, r_res.index};
    assign o_m_tuser  = r_res.kind;
    assign o_m_tlast  = r_res.text_last;

endmodule

>>> verif/tb_class_file_constant_pool_parser.sv
// Self-checking testbench for the class file constant pool parser.
// Streams class file images, predicts every result with its own parse model and
// compares each result field by field. Depends on cfcp_pkg and the parser RTL.
module tb_class_file_constant_pool_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import cfcp_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int BYTE_TARGET  = 1600;
    localparam int CALM_TAIL    = 300;
    localparam int SETTLE_LEN   = 8;
    localparam int PRINT_LIMIT  = 40;

    typedef enum int { FILE_GOOD, FILE_CUT, FILE_BAD_MAGIC, FILE_BAD_TAG } t_file_mode;

    // One request on the input stream, or a marker that holds the sender until drained
    typedef struct {
        logic [7:0] data;
        logic       start;
        bit         drain;
    } t_class_byte;

    typedef struct {
        logic [2:0]  kind;
        logic [15:0] index;
        logic [7:0]  tag;
        logic [63:0] value;
        logic [15:0] second;
        logic [7:0]  text;
        logic        last;
    } t_pool_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [7:0]          i_s_tdata;   // [7:0] byte_in
    logic [0:0]          i_s_tuser;   // [0] file_start
    logic                o_m_tvalid;
    logic                i_m_tready;
    // [15:0] entry_index, [23:16] entry_tag, [87:24] entry_value,
    // [103:88] second_ref, [111:104] text_byte
    logic [DATA_W-1:0]   o_m_tdata;
    logic [2:0]          o_m_tuser;   // [2:0] result_kind
    logic                o_m_tlast;   // text_last

    t_class_byte  class_bytes[$];
    t_pool_result pending_results[$];

    bit  byte_taken;
    int  src_gap;
    int  sink_gap;
    int  error_count;
    int  cycle_count;
    int  counted_bytes;
    int  sent_bytes;
    int  files_built;
    int  drains_done;
    int  kind_seen[5];

    // Parse model state
    logic [3:0]  phase;
    logic [3:0]  bytes_left;
    logic [63:0] shifter;
    logic [15:0] pool_cnt;
    logic [15:0] slot_no;
    logic [7:0]  cur_tag;
    logic [15:0] text_rem;

    class_file_constant_pool_parser uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- parse model

    function automatic void restart_parse();
        phase      = PH_MAGIC;
        bytes_left = 4'd4;
        shifter    = '0;
        pool_cnt   = '0;
        slot_no    = 16'd1;
        cur_tag    = '0;
        text_rem   = '0;
    endfunction

    // Body length of a tag in bytes, zero when the tag is not defined
    function automatic logic [3:0] tag_body_len(logic [7:0] tag);
        case (tag)
            TAG_UTF8, TAG_CLASS, TAG_STRING: return 4'd2;
            TAG_INTEGER, TAG_FLOAT: return 4'd4;
            TAG_LONG, TAG_DOUBLE: return 4'd8;
            TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF, TAG_NAMETYPE: return 4'd4;
            default: return 4'd0;
        endcase
    endfunction

    function automatic bit gather_byte(logic [7:0] b);
        shifter = {shifter[55:0], b};
        if (bytes_left != 0)
            bytes_left = bytes_left - 4'd1;
        return bytes_left == 0;
    endfunction

    // Advance the slot counter wide so a two-slot entry at the top cannot wrap
    function automatic void next_slot(int step);
        logic [16:0] nxt;
        nxt     = {1'b0, slot_no} + 17'(step);
        slot_no = nxt[15:0];
        phase   = (nxt < {1'b0, pool_cnt}) ? PH_TAG : PH_FINISH;
    endfunction

    function automatic void add_result(logic [2:0] kind, logic [15:0] index, logic [7:0] tag,
                                       logic [63:0] value, logic [15:0] second,
                                       logic [7:0] text, logic last);
        pending_results.push_back('{kind, index, tag, value, second, text, last});
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic start);
        logic [3:0] blen;
        if (start)
            restart_parse();
        case (phase)
            PH_MAGIC: begin
                if (gather_byte(b)) begin
                    if (shifter[31:0] != CLASS_MAGIC) begin
                        phase = PH_ERROR;
                        add_result(KIND_BAD_MAGIC, '0, '0, {32'd0, shifter[31:0]},
                                   '0, '0, 1'b0);
                    end else begin
                        phase      = PH_VERSION;
                        bytes_left = 4'd4;
                        shifter    = '0;
                    end
                end
            end
            PH_VERSION: begin
                if (gather_byte(b)) begin
                    phase      = PH_COUNT;
                    bytes_left = 4'd2;
                    shifter    = '0;
                end
            end
            PH_COUNT: begin
                if (gather_byte(b)) begin
                    pool_cnt = shifter[15:0];
                    slot_no  = 16'd1;
                    shifter  = '0;
                    phase    = (16'd1 < pool_cnt) ? PH_TAG : PH_FINISH;
                end
            end
            PH_TAG: begin
                blen    = tag_body_len(b);
                cur_tag = b;
                if (blen == 0) begin
                    phase = PH_ERROR;
                    add_result(KIND_BAD_TAG, slot_no, b, '0, '0, '0, 1'b0);
                end else begin
                    bytes_left = blen;
                    shifter    = '0;
                    phase      = PH_BODY;
                end
            end
            PH_BODY: begin
                if (gather_byte(b)) begin
                    case (cur_tag)
                        TAG_UTF8: begin
                            text_rem = shifter[15:0];
                            add_result(KIND_ENTRY, slot_no, TAG_UTF8, {48'd0, text_rem},
                                       '0, '0, 1'b0);
                            if (text_rem != 0)
                                phase = PH_TEXT;
                            else
                                next_slot(1);
                        end
                        TAG_INTEGER, TAG_FLOAT: begin
                            add_result(KIND_ENTRY, slot_no, cur_tag, {32'd0, shifter[31:0]},
                                       '0, '0, 1'b0);
                            next_slot(1);
                        end
                        TAG_LONG, TAG_DOUBLE: begin
                            add_result(KIND_ENTRY, slot_no, cur_tag, shifter, '0, '0, 1'b0);
                            next_slot(2);
                        end
                        TAG_CLASS, TAG_STRING: begin
                            add_result(KIND_ENTRY, slot_no, cur_tag, {48'd0, shifter[15:0]},
                                       '0, '0, 1'b0);
                            next_slot(1);
                        end
                        default: begin
                            add_result(KIND_ENTRY, slot_no, cur_tag, {48'd0, shifter[31:16]},
                                       shifter[15:0], '0, 1'b0);
                            next_slot(1);
                        end
                    endcase
                end
            end
            PH_TEXT: begin
                if (text_rem != 0)
                    text_rem = text_rem - 16'd1;
                add_result(KIND_TEXT, slot_no, TAG_UTF8, '0, '0, b, text_rem == 0);
                if (text_rem == 0)
                    next_slot(1);
            end
            PH_FINISH: begin
                phase = PH_DONE;
                add_result(KIND_FINISHED, pool_cnt, '0, '0, '0, '0, 1'b0);
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] mismatch %s: got %h, want %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic check_result();
        t_pool_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", {61'd0, o_m_tuser}, '0);
            return;
        end
        want = pending_results.pop_front();
        if (want.kind < 5)
            kind_seen[want.kind]++;
        if (o_m_tuser !== want.kind)
            report_mismatch("result_kind", {61'd0, o_m_tuser}, {61'd0, want.kind});
        if (o_m_tdata[15:0] !== want.index)
            report_mismatch("entry_index", {48'd0, o_m_tdata[15:0]}, {48'd0, want.index});
        if (o_m_tdata[23:16] !== want.tag)
            report_mismatch("entry_tag", {56'd0, o_m_tdata[23:16]}, {56'd0, want.tag});
        if (o_m_tdata[87:24] !== want.value)
            report_mismatch("entry_value", o_m_tdata[87:24], want.value);
        if (o_m_tdata[103:88] !== want.second)
            report_mismatch("second_ref", {48'd0, o_m_tdata[103:88]}, {48'd0, want.second});
        if (o_m_tdata[111:104] !== want.text)
            report_mismatch("text_byte", {56'd0, o_m_tdata[111:104]}, {56'd0, want.text});
        if (o_m_tlast !== want.last)
            report_mismatch("text_last", {63'd0, o_m_tlast}, {63'd0, want.last});
    endtask

    // Predict on every accepted request, then check every accepted result
    always @(posedge i_clk) begin
        byte_taken <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                parse_byte(i_s_tdata, i_s_tuser[0]);
                sent_bytes++;
            end
            if (o_m_tvalid && i_m_tready)
                check_result();
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_results.size());
            $display("tb_class_file_constant_pool_parser: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- drivers

    // Source side: hold a request until taken, then pick the next one or idle
    always @(negedge i_clk) begin : drive_source
        bit          nv;
        t_class_byte nx;
        nv = i_s_tvalid && !byte_taken;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!nv) begin
            if (src_gap > 0) begin
                src_gap--;
            end else if (class_bytes.size() > 0 && class_bytes[0].drain) begin
                if (pending_results.size() == 0) begin
                    void'(class_bytes.pop_front());
                    drains_done++;
                end
            end else if (class_bytes.size() > 0) begin
                nx = class_bytes.pop_front();
                i_s_tdata <= nx.data;
                i_s_tuser <= nx.start;
                nv = 1'b1;
                if (class_bytes.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
                    src_gap = $urandom_range(1, 11);
            end
        end
        i_s_tvalid <= nv;
    end

    // Sink side: stall in random bursts, never near the end
    always @(negedge i_clk) begin
        if (sink_gap > 0) begin
            sink_gap--;
            i_m_tready <= 1'b0;
        end else if (class_bytes.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(0, 10);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic void push_byte(logic [7:0] b, logic start, bit counted);
        class_bytes.push_back('{b, start, 1'b0});
        if (counted)
            counted_bytes++;
    endfunction

    // Push a big-endian field of n bytes
    function automatic void push_field(logic [63:0] v, int n, bit counted);
        for (int i = n - 1; i >= 0; i--)
            push_byte(v[8*i +: 8], 1'b0, counted);
    endfunction

    function automatic void push_drain();
        class_bytes.push_back('{8'd0, 1'b0, 1'b1});
    endfunction

    function automatic logic [63:0] rand_bits();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void push_junk(int n, bit first_counted);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom_range(0, 255)), 1'b0, first_counted && i == 0);
    endfunction

    function automatic void emit_file(t_file_mode mode);
        logic [31:0] magic;
        logic [15:0] count;
        logic [15:0] len;
        logic [7:0]  tg;
        int          slot;
        int          n;
        int          cut;
        int          bad_at;
        magic = CLASS_MAGIC;
        files_built++;
        if (mode == FILE_BAD_MAGIC) begin
            case ($urandom_range(0, 3))
                0: magic = $urandom;
                1: magic = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
                default: magic = magic ^ (32'd1 << $urandom_range(0, 31));
            endcase
        end
        push_byte(magic[31:24], 1'b1, 1'b1);
        push_field({40'd0, magic[23:0]}, 3, 1'b1);
        if (mode == FILE_BAD_MAGIC) begin
            push_junk($urandom_range(0, 3), 1'b0);
            return;
        end
        push_field(rand_bits(), 4, 1'b1);

        // Pick the pool size: mostly small, sometimes the edges
        case ($urandom_range(0, 15))
            0: count = 16'd0;
            1: count = 16'd1;
            2: count = 16'd2;
            3: count = (mode == FILE_CUT) ? 16'hFFFF : 16'd3;
            default: count = (mode == FILE_CUT) ? 16'($urandom) : 16'($urandom_range(3, 20));
        endcase
        if (mode == FILE_BAD_TAG)
            count = 16'($urandom_range(8, 40));
        push_field({48'd0, count}, 2, 1'b1);

        cut    = (mode == FILE_CUT) ? int'($urandom_range(0, 5)) : 1 << 30;
        bad_at = (mode == FILE_BAD_TAG) ? int'($urandom_range(0, 2)) : -1;
        slot   = 1;
        n      = 0;
        while (slot < count && n < cut) begin
            if (n == bad_at) begin
                case ($urandom_range(0, 4))
                    0: tg = 8'd0;
                    1: tg = 8'd2;
                    2: tg = 8'd13;
                    3: tg = 8'd255;
                    default: begin
                        do tg = 8'($urandom_range(0, 255)); while (tag_body_len(tg) != 0);
                    end
                endcase
                push_byte(tg, 1'b0, 1'b1);
                push_junk($urandom_range(0, 3), 1'b0);
                return;
            end
            case ($urandom_range(0, 10))
                0: tg = TAG_UTF8;
                1: tg = TAG_INTEGER;
                2: tg = TAG_FLOAT;
                3: tg = TAG_LONG;
                4: tg = TAG_DOUBLE;
                5: tg = TAG_CLASS;
                6: tg = TAG_STRING;
                7: tg = TAG_FIELDREF;
                8: tg = TAG_METHODREF;
                9: tg = TAG_IMETHODREF;
                default: tg = TAG_NAMETYPE;
            endcase
            push_byte(tg, 1'b0, 1'b1);
            if (tg == TAG_UTF8) begin
                case ($urandom_range(0, 19))
                    0, 1, 2: len = 16'd0;
                    3: len = 16'($urandom_range(9, 40));
                    default: len = 16'($urandom_range(1, 8));
                endcase
                push_field({48'd0, len}, 2, 1'b1);
                for (int i = 0; i < len; i++)
                    push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end else begin
                push_field(rand_bits(), int'(tag_body_len(tg)), 1'b1);
            end
            slot += (tg == TAG_LONG || tg == TAG_DOUBLE) ? 2 : 1;
            n++;
        end
        if (mode == FILE_CUT && slot < count) begin
            // Leave the next entry half written
            push_junk($urandom_range(0, 3), 1'b1);
            return;
        end
        push_junk($urandom_range(0, 3), 1'b1);
    endfunction

    initial begin
        int pick;
        bit mid_drain;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        i_m_tready = 1'b0;
        mid_drain  = 1'b0;
        restart_parse();

        // Directed: a file with no start flag and an empty pool
        push_field({32'd0, CLASS_MAGIC}, 4, 1'b1);
        push_field(64'h0000_0034, 4, 1'b1);
        push_field(64'h0000, 2, 1'b1);
        push_byte(8'hFF, 1'b0, 1'b1);
        // Directed: bad magic, then a byte that must be dropped
        push_byte(8'hCA, 1'b1, 1'b1);
        push_field(64'hFEBABF, 3, 1'b1);
        push_byte(8'h00, 1'b0, 1'b0);
        // Directed: unknown tag in the first slot
        push_byte(8'hCA, 1'b1, 1'b1);
        push_field(64'hFEBABE, 3, 1'b1);
        push_field(64'hFFFF_FFFF, 4, 1'b1);
        push_field(64'h0002, 2, 1'b1);
        push_byte(8'h00, 1'b0, 1'b1);
        push_drain();

        // Random: mostly well-formed images, the rest broken ones and noise
        while (counted_bytes < BYTE_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                emit_file(FILE_GOOD);
            else if (pick < 80)
                emit_file(FILE_CUT);
            else if (pick < 88)
                emit_file(FILE_BAD_MAGIC);
            else if (pick < 95)
                emit_file(FILE_BAD_TAG);
            else
                for (int i = $urandom_range(1, 8); i > 0; i--)
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b1);
            if (!mid_drain && counted_bytes >= BYTE_TARGET / 2) begin
                push_drain();
                mid_drain = 1'b1;
            end
        end

        // Hold reset, then release on a falling edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to be taken and every result to arrive
        while (class_bytes.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_LEN) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results left pending", 64'(pending_results.size()), '0);

        $display("sent %0d bytes in %0d file images, %0d drain pauses",
                 sent_bytes, files_built, drains_done);
        $display("checked %0d entries, %0d text bytes, %0d pool ends,",
                 kind_seen[KIND_ENTRY], kind_seen[KIND_TEXT], kind_seen[KIND_FINISHED]);
        $display("  %0d bad magic, %0d bad tags",
                 kind_seen[KIND_BAD_MAGIC], kind_seen[KIND_BAD_TAG]);
        if (error_count == 0) begin
            $display("tb_class_file_constant_pool_parser: clean");
        end else begin
            $display("tb_class_file_constant_pool_parser: errors");
        end
        $finish;
    end

endmodule
